FILE: design/min_priority_queue_top_macros.svh
`ifndef MIN_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MIN_PRIORITY_QUEUE_TOP_MACROS_SVH

// Checks that are off while reset is high.
`define MPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that also hold across reset.
`define MPQ_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int OP_W   = 2;
   localparam int KEY_W  = 32;
   localparam int PAY_W  = 32;
   localparam int FILL_W = 5;
   localparam int STAT_W = 2;

   localparam int ENT_W      = KEY_W + PAY_W;
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - PAY_W - KEY_W - FILL_W;
   localparam int RSP_USER_W = STAT_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PEEK   = 2'd2
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic sample;
      logic first;
   } best_ctl_type;

endpackage

`default_nettype wire

FILE: design/mpq_ram.sv
`default_nettype none

module mpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/mpq_best.sv
`default_nettype none

module mpq_best
   import mpq_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  wire logic               clock,
   input  wire best_ctl_type       ctl,
   input  wire logic [IDX_W-1:0]   cand_idx,
   input  wire logic [KEY_W-1:0]   cand_key,
   input  wire logic [PAY_W-1:0]   cand_payload,
   output logic      [IDX_W-1:0]   best_idx,
   output logic      [KEY_W-1:0]   best_key,
   output logic      [PAY_W-1:0]   best_payload
);

   logic [IDX_W-1:0] idx_ff;
   logic [KEY_W-1:0] key_ff;
   logic [PAY_W-1:0] pay_ff;
   logic             take;

   // strict less: on equal keys the earlier entry stays
   assign take = ctl.sample && (ctl.first || ($signed(cand_key) < $signed(key_ff)));

   always_ff @(posedge clock) begin
      if (take) begin
         idx_ff <= cand_idx;
         key_ff <= cand_key;
         pay_ff <= cand_payload;
      end
   end

   assign best_idx     = idx_ff;
   assign best_key     = key_ff;
   assign best_payload = pay_ff;

endmodule

`default_nettype wire

FILE: design/min_priority_queue_top.sv
`default_nettype none
// Channel   Ports   tdata (low bit up)                      tuser
// request   req_*   key[31:0] payload[63:32]               opcode[1:0]
// response  rsp_*   out_payload[31:0] out_key[63:32]        status[1:0]
//                   fill_count[68:64] zero[71:69]
//
// Insert, empty remove or peek, full insert and opcode three go straight to the reply step.
// Peek: the scan reads one entry a cycle from the single read port of the entry RAM
// through one signed compare unit.
// Remove: after the same scan, the entries above the minimum move down one place
// to close the gap; when the minimum is the last entry, no entry moves.
// Reset clears the count and the control state; the entry RAM is not cleared.
// A result waiting on rsp_tready sits in the output register while the next
// transaction is accepted; the sequencer stalls only at its own reply step.

module min_priority_queue_top
   import mpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // key, payload
   input  wire logic [REQ_USER_W-1:0] req_tuser,   // opcode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // out_payload, out_key, fill_count
   output logic      [RSP_USER_W-1:0] rsp_tuser    // status
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              hit_ff, hit_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic              accept;
   logic              full;
   logic              rsp_free;
   logic              issue;
   logic [CNT_W-1:0]  wr_idx;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [ENT_W-1:0]  ram_wdata;
   logic              ram_re;
   logic [IDX_W-1:0]  ram_raddr;
   logic [ENT_W-1:0]  ram_rdata;

   best_ctl_type      best_ctl;
   logic [IDX_W-1:0]  best_idx;
   logic [KEY_W-1:0]  best_key;
   logic [PAY_W-1:0]  best_payload;

   // entry layout in RAM: payload high, key low
   mpq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_mpq_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mpq_best #(
      .IDX_W (IDX_W)
   ) u_mpq_best (
      .clock        (clock),
      .ctl          (best_ctl),
      .cand_idx     (rd_idx_ff[IDX_W-1:0]),
      .cand_key     (ram_rdata[KEY_W-1:0]),
      .cand_payload (ram_rdata[ENT_W-1:KEY_W]),
      .best_idx     (best_idx),
      .best_key     (best_key),
      .best_payload (best_payload)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff >= CNT_W'(CAPACITY));
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign issue      = (scan_ff < count_ff);
   assign wr_idx     = rd_idx_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      hit_in       = hit_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      best_ctl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_tuser;
               hit_in    = 1'b0;
               status_in = ST_OK;
               scan_in   = '0;
               state_in  = S_RESP;
               case (opcode_type'(req_tuser))
                  OP_INSERT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[IDX_W-1:0];
                        ram_wdata = {req_tdata[63:32], req_tdata[31:0]};
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE, OP_PEEK: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               ram_re    = 1'b1;
               ram_raddr = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff;
            end
            if (rd_vld_ff) begin
               best_ctl.sample = 1'b1;
               best_ctl.first  = (rd_idx_ff == '0);
            end
            if (!issue && !rd_vld_ff) begin
               hit_in = 1'b1;
               if (op_ff == OP_REMOVE) begin
                  scan_in  = CNT_W'(best_idx) + CNT_W'(1);
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SHIFT: begin
            // read entry j while entry j-2 takes the word of entry j-1 from the previous read
            if (issue) begin
               ram_re    = 1'b1;
               ram_raddr = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff;
            end
            if (rd_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_idx[IDX_W-1:0];
               ram_wdata = ram_rdata;
            end
            if (!issue && !rd_vld_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {{RSP_PAD_W{1'b0}},
                               FILL_W'(count_ff),
                               hit_ff ? best_key : {KEY_W{1'b0}},
                               hit_ff ? best_payload : {PAY_W{1'b0}}};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      status_ff   <= status_in;
      hit_ff      <= hit_in;
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: design/mpq_checker.sv
`default_nettype none
`include "min_priority_queue_top_macros.svh"

module mpq_checker
   import mpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,   // key, payload
   input wire logic [REQ_USER_W-1:0] req_tuser,   // opcode
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,   // out_payload, out_key, fill_count
   input wire logic [RSP_USER_W-1:0] rsp_tuser    // status
);

   `MPQ_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   `MPQ_ASSERT(a_one_item, req_tvalid && req_tready |=> !req_tready, "second transaction taken while busy")

   `MPQ_ASSERT(a_empty_zero, rsp_tvalid && (rsp_tuser == ST_EMPTY) |-> (rsp_tdata == '0), "empty response carries data or count")

   `MPQ_ASSERT(a_full_count, rsp_tvalid && (rsp_tuser == ST_FULL) |-> (rsp_tdata[68:64] == FILL_W'(CAPACITY)), "full status without full count")

   `MPQ_ASSERT_RST(a_reset_idle, $past(reset) |-> !rsp_tvalid && req_tready, "not idle after reset")

endmodule

bind min_priority_queue_top mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (.*);

`default_nettype wire
